/* hdl/ip_prefix_aggregation_set_assert.svh */
// Assertion macros shared by the prefix set RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef IP_PREFIX_AGGREGATION_SET_ASSERT_SVH
`define IP_PREFIX_AGGREGATION_SET_ASSERT_SVH

// same-cycle implication
`define IPAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ipas_pkg.sv */
// Package for the IPv4 prefix set: beat types, codes, token type, mask function.
// No dependencies; imported by ipas_cell and ip_prefix_aggregation_set.
package ipas_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ADDR_W       = 32;
  localparam int LEN_W        = 6;
  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PRUNE  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_COVERED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_PRUNED    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // token operations walking the cell chain
  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PRUNE  = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] req_address;
    logic [LEN_W-1:0]  req_length;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [6:0]        deleted_count;
    logic [ADDR_W-1:0] match_address;
    logic [LEN_W-1:0]  match_length;
    logic [6:0]        entries_used;
  } rsp_t;

  typedef struct packed {
    logic              vld;
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              hit;
    logic [ADDR_W-1:0] m_addr;
    logic [LEN_W-1:0]  m_len;
  } tok_t;

  // len is at most 32
  function automatic logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

/* hdl/ipas_cell.sv */
// One slot of the prefix set plus the token register to the next cell.
// Depends on ipas_pkg.
module ipas_cell import ipas_pkg::*; #(
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  tok_t          tok_in,
  input  logic [CW-1:0] cnt_in,
  output tok_t          tok_out,
  output logic [CW-1:0] cnt_out
);

  logic [ADDR_W-1:0] slot_address;
  logic [LEN_W-1:0]  slot_length;
  logic              slot_valid;

  tok_t          tok_next;
  logic [CW-1:0] cnt_next;
  logic          valid_next;
  logic          wr;
  logic          agree_own;
  logic          agree_req;
  logic          contained;

  always_comb begin
    agree_own = ((slot_address ^ tok_in.addr) & prefix_mask(slot_length)) == '0;
    agree_req = ((slot_address ^ tok_in.addr) & prefix_mask(tok_in.len)) == '0;
    contained = slot_valid && (slot_length >= tok_in.len) && agree_req;
    tok_next = tok_in;
    cnt_next = cnt_in;
    valid_next = slot_valid;
    wr = 1'b0;
    if (tok_in.vld) begin
      case (tok_in.op)
        OP_CHECK: begin
          if (!tok_in.hit && slot_valid && (slot_length <= tok_in.len) && agree_own) begin
            tok_next.hit = 1'b1;
            tok_next.m_addr = slot_address;
            tok_next.m_len = slot_length;
          end
        end
        OP_INSERT: begin
          if (contained) begin
            valid_next = 1'b0;
            cnt_next = cnt_in + CW'(1);
          end
          if ((!slot_valid || contained) && !tok_in.hit) begin
            wr = 1'b1;
            valid_next = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!tok_in.hit && slot_valid && (slot_address == tok_in.addr) &&
              (slot_length == tok_in.len)) begin
            valid_next = 1'b0;
            tok_next.hit = 1'b1;
          end
        end
        OP_PRUNE: begin
          if (contained) begin
            valid_next = 1'b0;
            cnt_next = cnt_in + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      slot_valid <= valid_next;
      tok_out    <= tok_next;
      cnt_out    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_address <= tok_in.addr;
      slot_length  <= tok_in.len;
    end
  end

endmodule

/* hdl/ip_prefix_aggregation_set.sv */
// IPv4 prefix set kept free of overlap: insert with aggregation, exact remove, prune.
// Block usage:
//   req channel (in_valid/in_ready, req_t): one request beat per operation.
//   rsp channel (out_valid/out_ready, rsp_t): exactly one result beat per request.
//   A request token walks a chain of CAPACITY cells, one cell per cycle; each
//   cell holds one slot. Insert makes a cover-check pass and, if not covered,
//   a second pass (absorb and store); remove and prune make one pass.
//   An unknown request type skips the chain and goes straight to the result.
//   One request is in work at a time; in_ready is high only when idle, so a new
//   request is taken only after the previous result has entered the output register.
//   Reset clears all slot valid bits and the entry count at once; no sweep.
//   The result sits in an output register; a stalled receiver holds the next
//   result in the block, and no further request is taken until it drains.
// Depends on ipas_pkg, ipas_cell and ip_prefix_aggregation_set_assert.svh.
`include "ip_prefix_aggregation_set_assert.svh"

module ip_prefix_aggregation_set import ipas_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  tok_t          head;
  logic [CW-1:0] used_count;
  rsp_t          hold;

  tok_t          chain_tok [CAPACITY+1];
  logic [CW-1:0] chain_cnt [CAPACITY+1];
  logic [CAPACITY:0] tok_vld;

  tok_t          tail;
  logic [CW-1:0] tail_cnt;
  rsp_t          fin;
  logic [CW-1:0] used_next;
  logic          relaunch;
  logic [LEN_W-1:0] len_c;
  tok_t          launch;
  logic          known;
  logic          load_out;

  assign chain_tok[0] = head;
  assign chain_cnt[0] = '0;
  assign tok_vld[0] = head.vld;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      ipas_cell #(.CW(CW)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain_tok[g]),
        .cnt_in  (chain_cnt[g]),
        .tok_out (chain_tok[g+1]),
        .cnt_out (chain_cnt[g+1])
      );
      assign tok_vld[g+1] = chain_tok[g+1].vld;
    end
  endgenerate

  assign tail = chain_tok[CAPACITY];
  assign tail_cnt = chain_cnt[CAPACITY];
  assign in_ready = (state == S_IDLE);
  assign len_c = (req.req_length > MAX_LEN) ? MAX_LEN : req.req_length;
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    launch = '{vld: 1'b1, op: OP_CHECK, addr: req.req_address, len: len_c,
               hit: 1'b0, m_addr: '0, m_len: '0};
    known = 1'b1;
    case (req.req_type)
      REQ_INSERT: launch.op = OP_CHECK;
      REQ_REMOVE: launch.op = OP_REMOVE;
      REQ_PRUNE:  launch.op = OP_PRUNE;
      default:    known = 1'b0;
    endcase
  end

  always_comb begin
    fin = '0;
    fin.status = ST_NOT_FOUND;
    used_next = used_count;
    relaunch = 1'b0;
    case (tail.op)
      OP_CHECK: begin
        if (tail.hit) begin
          fin.status = ST_COVERED;
          fin.match_address = tail.m_addr;
          fin.match_length = tail.m_len;
        end else begin
          relaunch = 1'b1;
        end
      end
      OP_INSERT: begin
        fin.deleted_count = 7'(tail_cnt);
        if (tail.hit) begin
          fin.status = ST_INSERTED;
          used_next = used_count - tail_cnt + CW'(1);
        end else begin
          fin.status = ST_FULL;
          used_next = used_count - tail_cnt;
        end
      end
      OP_REMOVE: begin
        if (tail.hit) begin
          fin.status = ST_REMOVED;
          used_next = used_count - CW'(1);
        end
      end
      OP_PRUNE: begin
        fin.status = ST_PRUNED;
        fin.deleted_count = 7'(tail_cnt);
        used_next = used_count - tail_cnt;
      end
      default: ;
    endcase
    fin.entries_used = 7'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head.vld   <= 1'b0;
      used_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (known) begin
              head  <= launch;
              state <= S_RUN;
            end else begin
              hold <= '{status: ST_NOT_FOUND, deleted_count: 7'd0,
                        match_address: '0, match_length: '0,
                        entries_used: 7'(used_count)};
              state <= S_FIN;
            end
          end
        end
        S_RUN: begin
          if (tail.vld && relaunch) begin
            head <= '{vld: 1'b1, op: OP_INSERT, addr: tail.addr, len: tail.len,
                      hit: 1'b0, m_addr: '0, m_len: '0};
          end else begin
            head.vld <= 1'b0;
            if (tail.vld) begin
              hold       <= fin;
              used_count <= used_next;
              state      <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= hold;
    end
  end

  `IPAS_ASSERT_IMP(a_one_token, clk, rst, 1'b1, $onehot0(tok_vld), "more than one token in chain")
  `IPAS_ASSERT_IMP(a_idle_empty, clk, rst, in_ready, tok_vld == '0, "token in chain while idle")
  `IPAS_ASSERT_IMP(a_used_range, clk, rst, 1'b1, used_count <= CW'(CAPACITY), "entry count overflow")
  `IPAS_ASSERT_NXT(a_second_pass, clk, rst,
                   (state == S_RUN) && tail.vld && relaunch,
                   head.vld && (head.op == OP_INSERT), "insert pass not launched")

endmodule
